>>> rtl/cst_pkg.sv
// shared types and constants for the count and sum segment tree
package cst_pkg;

  localparam int unsigned LEAF_COUNT_W = 11;
  localparam int unsigned POS_W        = 10;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned SUM_W        = 64;

  localparam logic [LEAF_COUNT_W-1:0] LEAF_COUNT_RST = 11'd1024;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
  } node_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

>>> rtl/cst_if.sv
// request, response and configuration channel interfaces
interface cst_req_if;
  import cst_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [POS_W-1:0]        position_lo;
  logic [POS_W-1:0]        position_hi;
  logic signed [VAL_W-1:0] add_value;

  modport source (output valid, req_type, position_lo, position_hi, add_value, input ready);
  modport sink   (input valid, req_type, position_lo, position_hi, add_value, output ready);
endinterface

interface cst_rsp_if;
  import cst_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CNT_W-1:0]        range_count;
  logic signed [SUM_W-1:0] range_sum;

  modport source (output valid, range_count, range_sum, input ready);
  modport sink   (input valid, range_count, range_sum, output ready);
endinterface

interface cst_cfg_if;
  import cst_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [LEAF_COUNT_W-1:0] leaf_count;

  modport source (output valid, leaf_count, input ready);
  modport sink   (input valid, leaf_count, output ready);
endinterface

>>> rtl/cst_alu.sv
// shared adder for node counts and sums
module cst_alu (
  input  cst_pkg::node_t a_i,
  input  cst_pkg::node_t b_i,
  output cst_pkg::node_t res_o
);
  import cst_pkg::*;

  assign res_o.cnt = a_i.cnt + b_i.cnt;
  assign res_o.sum = a_i.sum + b_i.sum;

endmodule

>>> rtl/cst_node_mem.sv
// node store, one write port and two registered read ports
module cst_node_mem #(
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  cst_pkg::mem_ctl_t        ctl_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  cst_pkg::node_t           wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output cst_pkg::node_t           rdata0_o,
  output cst_pkg::node_t           rdata1_o
);
  import cst_pkg::*;

  node_t mem_q [DEPTH];
  node_t rdata0_q;
  node_t rdata1_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

>>> rtl/cst_ctrl.sv
// sequencer for clearing, tree updates and range queries
module cst_ctrl #(
  parameter int unsigned MAX_LEAVES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cst_req_if.sink                             req_i,
  cst_rsp_if.source                           rsp_o,
  cst_cfg_if.sink                             cfg_i,
  output cst_pkg::mem_ctl_t                   mem_ctl_o,
  output logic [$clog2(2*MAX_LEAVES)-1:0]     mem_waddr_o,
  output cst_pkg::node_t                      mem_wdata_o,
  output logic [$clog2(2*MAX_LEAVES)-1:0]     mem_raddr0_o,
  output logic [$clog2(2*MAX_LEAVES)-1:0]     mem_raddr1_o,
  input  cst_pkg::node_t                      mem_rdata0_i,
  input  cst_pkg::node_t                      mem_rdata1_i,
  output cst_pkg::node_t                      alu_a_o,
  output cst_pkg::node_t                      alu_b_o,
  input  cst_pkg::node_t                      alu_res_i
);
  import cst_pkg::*;

  localparam int unsigned DEPTH = 2 * MAX_LEAVES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned KW    = (CW > LEAF_COUNT_W) ? CW : LEAF_COUNT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_U_LEAF,
    S_U_UP,
    S_Q_ISSUE,
    S_Q_ADDA,
    S_Q_ADDB,
    S_Q_DONE
  } state_e;

  state_e                  state_q;
  logic [AW-1:0]           clr_q;
  logic [LEAF_COUNT_W-1:0] lc_q;
  logic [AW-1:0]           p_q;
  logic [CW-1:0]           a_q;
  logic [CW-1:0]           b_q;
  logic                    tka_q;
  logic                    tkb_q;
  node_t                   cur_q;
  node_t                   acc_q;
  logic signed [VAL_W-1:0] delta_q;
  logic                    rsp_valid_q;
  logic [CNT_W-1:0]        rsp_cnt_q;
  logic [SUM_W-1:0]        rsp_sum_q;

  logic [KW-1:0] lc_ext;
  logic [KW-1:0] max_ext;
  logic [KW-1:0] n_eff;
  logic [KW-1:0] lo_ext;
  logic [KW-1:0] hi_ext;
  logic [KW-1:0] hi_clamp;
  logic [KW-1:0] lo_node;
  logic [KW-1:0] hi_node;
  logic          upd_ok;
  logic          q_empty;
  logic          accept;
  logic          rsp_free;
  logic          take_a;
  logic          take_b;
  logic [CW-1:0] a_nx;
  logic [CW-1:0] b_nx;
  logic          walk_more;
  logic          walk_last;

  // effective leaf count and node numbers of the request
  always_comb begin
    lc_ext  = KW'(lc_q);
    max_ext = KW'(MAX_LEAVES);
    if (lc_ext == '0) begin
      n_eff = KW'(1);
    end else if (lc_ext > max_ext) begin
      n_eff = max_ext;
    end else begin
      n_eff = lc_ext;
    end
    lo_ext   = KW'(req_i.position_lo);
    hi_ext   = KW'(req_i.position_hi);
    hi_clamp = (hi_ext >= n_eff) ? (n_eff - KW'(1)) : hi_ext;
    lo_node  = lo_ext + n_eff;
    hi_node  = hi_clamp + n_eff;
    upd_ok   = lo_ext < n_eff;
    q_empty  = lo_ext > hi_clamp;
  end

  // one level of the bottom-up range walk
  always_comb begin
    take_a    = a_q[0];
    take_b    = ~b_q[0];
    a_nx      = (a_q + CW'(take_a)) >> 1;
    b_nx      = (b_q - CW'(take_b)) >> 1;
    walk_more = a_q <= b_q;
    walk_last = (p_q >> 1) == '0;
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign accept            = req_i.valid && req_i.ready;
  assign rsp_free          = !rsp_valid_q || rsp_o.ready;
  assign cfg_i.ready       = 1'b1;
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.range_count = rsp_cnt_q;
  assign rsp_o.range_sum   = rsp_sum_q;

  always_comb begin
    mem_ctl_o    = '0;
    mem_waddr_o  = p_q;
    mem_wdata_o  = alu_res_i;
    mem_raddr0_o = a_q[AW-1:0];
    mem_raddr1_o = b_q[AW-1:0];
    alu_a_o      = acc_q;
    alu_b_o      = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = clr_q;
        mem_wdata_o  = '0;
      end
      S_IDLE: begin
        if (accept && req_i.req_type == REQ_UPDATE && upd_ok) begin
          mem_ctl_o.re = 1'b1;
          mem_raddr0_o = lo_node[AW-1:0];
        end
      end
      S_U_LEAF: begin
        alu_a_o      = mem_rdata0_i;
        alu_b_o.cnt  = CNT_W'(1);
        alu_b_o.sum  = SUM_W'(delta_q);
        mem_ctl_o.we = 1'b1;
        mem_ctl_o.re = !walk_last;
        mem_raddr0_o = p_q ^ AW'(1);
      end
      S_U_UP: begin
        alu_a_o      = cur_q;
        alu_b_o      = mem_rdata0_i;
        mem_ctl_o.we = 1'b1;
        mem_ctl_o.re = !walk_last;
        mem_raddr0_o = p_q ^ AW'(1);
      end
      S_Q_ISSUE: begin
        mem_ctl_o.re = 1'b1;
      end
      S_Q_ADDA: begin
        alu_b_o = tka_q ? mem_rdata0_i : '0;
      end
      S_Q_ADDB: begin
        alu_b_o      = tkb_q ? mem_rdata1_i : '0;
        mem_ctl_o.re = walk_more;
      end
      S_Q_DONE: begin
        mem_ctl_o = '0;
      end
      default: begin
        mem_ctl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      lc_q        <= LEAF_COUNT_RST;
      p_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      tka_q       <= 1'b0;
      tkb_q       <= 1'b0;
      cur_q       <= '0;
      acc_q       <= '0;
      delta_q     <= '0;
      rsp_valid_q <= 1'b0;
      rsp_cnt_q   <= '0;
      rsp_sum_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        lc_q <= cfg_i.leaf_count;
      end
      if (rsp_valid_q && rsp_o.ready && state_q != S_Q_DONE) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (req_i.req_type == REQ_UPDATE) begin
              delta_q <= req_i.add_value;
              p_q     <= lo_node[AW-1:0];
              if (upd_ok) begin
                state_q <= S_U_LEAF;
              end
            end else begin
              acc_q   <= '0;
              a_q     <= lo_node[CW-1:0];
              b_q     <= hi_node[CW-1:0];
              state_q <= q_empty ? S_Q_DONE : S_Q_ISSUE;
            end
          end
        end
        S_U_LEAF, S_U_UP: begin
          cur_q <= alu_res_i;
          if (walk_last) begin
            state_q <= S_IDLE;
          end else begin
            p_q     <= p_q >> 1;
            state_q <= S_U_UP;
          end
        end
        S_Q_ISSUE: begin
          tka_q   <= take_a;
          tkb_q   <= take_b;
          a_q     <= a_nx;
          b_q     <= b_nx;
          state_q <= S_Q_ADDA;
        end
        S_Q_ADDA: begin
          acc_q   <= alu_res_i;
          state_q <= S_Q_ADDB;
        end
        S_Q_ADDB: begin
          acc_q <= alu_res_i;
          if (walk_more) begin
            tka_q   <= take_a;
            tkb_q   <= take_b;
            a_q     <= a_nx;
            b_q     <= b_nx;
            state_q <= S_Q_ADDA;
          end else begin
            state_q <= S_Q_DONE;
          end
        end
        S_Q_DONE: begin
          if (rsp_free) begin
            rsp_valid_q <= 1'b1;
            rsp_cnt_q   <= acc_q.cnt;
            rsp_sum_q   <= acc_q.sum;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_no_write_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_Q_ISSUE || state_q == S_Q_ADDA || state_q == S_Q_ADDB ||
     state_q == S_Q_DONE) |-> !mem_ctl_o.we)
    else $error("node store written during a range query");

  a_walk_below_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_U_UP) |-> (p_q != '0))
    else $error("update walk went past the root");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_Q_DONE))
    else $error("response raised outside query completion");

  a_adda_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_Q_ADDA) |-> ($past(state_q) == S_Q_ISSUE || $past(state_q) == S_Q_ADDB))
    else $error("query accumulate entered out of order");

endmodule

>>> rtl/count_sum_segment_tree.sv
// top level: bottom-up segment tree of insert counts and sums over a shared adder
// update: the leaf is read on acceptance, then the leaf and each ancestor up to the root are rewritten in turn
// query: an issue state, then an add state for each side per tree level visited, then the result is loaded
// one request is handled at a time over the single adder; a new one is taken only when idle
// reset: leaf count returns to 1024 and a clearing pass over all 2*MAX_LEAVES nodes zeroes the store
// requests are held off during the clearing pass, configuration writes are taken at any time
module count_sum_segment_tree #(
  parameter int unsigned MAX_LEAVES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cst_req_if.sink   req_i,
  cst_rsp_if.source rsp_o,
  cst_cfg_if.sink   cfg_i
);
  import cst_pkg::*;

  localparam int unsigned DEPTH = 2 * MAX_LEAVES;
  localparam int unsigned AW    = $clog2(DEPTH);

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_waddr;
  node_t         mem_wdata;
  logic [AW-1:0] mem_raddr0;
  logic [AW-1:0] mem_raddr1;
  node_t         mem_rdata0;
  node_t         mem_rdata1;
  node_t         alu_a;
  node_t         alu_b;
  node_t         alu_res;

  cst_ctrl #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .cfg_i        (cfg_i),
    .mem_ctl_o    (mem_ctl),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr0_o (mem_raddr0),
    .mem_raddr1_o (mem_raddr1),
    .mem_rdata0_i (mem_rdata0),
    .mem_rdata1_i (mem_rdata1),
    .alu_a_o      (alu_a),
    .alu_b_o      (alu_b),
    .alu_res_i    (alu_res)
  );

  cst_node_mem #(
    .DEPTH (DEPTH)
  ) u_node_mem (
    .clk_i    (clk_i),
    .ctl_i    (mem_ctl),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr0_i (mem_raddr0),
    .raddr1_i (mem_raddr1),
    .rdata0_o (mem_rdata0),
    .rdata1_o (mem_rdata1)
  );

  cst_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

endmodule

>>> test/tb_count_sum_segment_tree.sv
// testbench for count_sum_segment_tree: directed table, then random requests checked against a predictor
`timescale 1ns / 1ps

module tb_count_sum_segment_tree;
  import cst_pkg::*;

  localparam int unsigned MAX_LEAVES  = 1024;
  localparam int unsigned NODE_DEPTH  = 2 * MAX_LEAVES;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_HOLD  = 64;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_REQS  = 117;
  localparam int unsigned DIR_ROWS    = 20;

  typedef struct {
    logic                    kind;
    logic [POS_W-1:0]        lo;
    logic [POS_W-1:0]        hi;
    logic signed [VAL_W-1:0] val;
  } req_t;

  typedef struct {
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sum;
  } totals_t;

  typedef struct {
    logic                    kind;
    logic [POS_W-1:0]        lo;
    logic [POS_W-1:0]        hi;
    logic signed [VAL_W-1:0] val;
    bit                      typed;
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sum;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  cst_req_if req_ch ();
  cst_rsp_if rsp_ch ();
  cst_cfg_if cfg_ch ();

  count_sum_segment_tree #(
    .MAX_LEAVES(MAX_LEAVES)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  // predictor state
  logic [SUM_W-1:0]        sum_tree [NODE_DEPTH];
  logic [CNT_W-1:0]        hit_tree [NODE_DEPTH];
  logic [LEAF_COUNT_W-1:0] leaf_cfg;

  totals_t     totals_q [$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned take_idle_pct;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{REQ_QUERY,  10'd0,    10'd1023, 32'sd0,           1'b1, 32'd0, 64'sd0},
    '{REQ_QUERY,  10'd1023, 10'd0,    32'sd0,           1'b1, 32'd0, 64'sd0},
    '{REQ_UPDATE, 10'd0,    10'd0,    32'sh7fffffff,    1'b0, 32'd0, 64'sd0},
    '{REQ_UPDATE, 10'd1023, 10'd1023, 32'sh80000000,    1'b0, 32'd0, 64'sd0},
    '{REQ_QUERY,  10'd0,    10'd1023, 32'sd0,           1'b1, 32'd2, -64'sd1},
    '{REQ_QUERY,  10'd0,    10'd0,    32'sd0,           1'b1, 32'd1, 64'sd2147483647},
    '{REQ_QUERY,  10'd1023, 10'd1023, 32'sd0,           1'b1, 32'd1, -64'sd2147483648},
    '{REQ_UPDATE, 10'd512,  10'd0,    -32'sd1,          1'b0, 32'd0, 64'sd0},
    '{REQ_UPDATE, 10'd511,  10'd1023, 32'sd1,           1'b0, 32'd0, 64'sd0},
    '{REQ_QUERY,  10'd1,    10'd1022, 32'sd0,           1'b1, 32'd2, 64'sd0},
    '{REQ_UPDATE, 10'd0,    10'd0,    32'sh7fffffff,    1'b0, 32'd0, 64'sd0},
    '{REQ_QUERY,  10'd0,    10'd0,    32'sd0,           1'b1, 32'd2, 64'sd4294967294},
    '{REQ_UPDATE, 10'd341,  10'd682,  32'sh55555555,    1'b0, 32'd0, 64'sd0},
    '{REQ_UPDATE, 10'd682,  10'd341,  32'shaaaaaaaa,    1'b0, 32'd0, 64'sd0},
    '{REQ_QUERY,  10'd341,  10'd682,  32'sh55555555,    1'b0, 32'd0, 64'sd0},
    '{REQ_QUERY,  10'd0,    10'd1023, 32'shaaaaaaaa,    1'b0, 32'd0, 64'sd0},
    '{REQ_QUERY,  10'd1000, 10'd1023, 32'sd0,           1'b0, 32'd0, 64'sd0},
    '{REQ_QUERY,  10'd0,    10'd511,  32'sd0,           1'b0, 32'd0, 64'sd0},
    '{REQ_QUERY,  10'd512,  10'd1023, 32'sd0,           1'b0, 32'd0, 64'sd0},
    '{REQ_QUERY,  10'd600,  10'd599,  32'sd0,           1'b1, 32'd0, 64'sd0}
  };

  function automatic int unsigned leaves_in_use();
    int unsigned n;
    n = 32'(leaf_cfg);
    if (n == 0) n = 1;
    if (n > MAX_LEAVES) n = MAX_LEAVES;
    return n;
  endfunction

  function automatic void apply_update(input int unsigned pos, input logic signed [VAL_W-1:0] val);
    int unsigned      n;
    int unsigned      p;
    logic [SUM_W-1:0] delta;
    n = leaves_in_use();
    if (pos >= n) return;
    delta = {{(SUM_W-VAL_W){val[VAL_W-1]}}, val};
    p = pos + n;
    sum_tree[p] = sum_tree[p] + delta;
    hit_tree[p] = hit_tree[p] + 1;
    p = p >> 1;
    while (p >= 1) begin
      sum_tree[p] = sum_tree[2*p] + sum_tree[2*p+1];
      hit_tree[p] = hit_tree[2*p] + hit_tree[2*p+1];
      p = p >> 1;
    end
  endfunction

  function automatic totals_t range_total(input int unsigned lo, input int unsigned hi);
    int unsigned n;
    int unsigned a;
    int unsigned b;
    totals_t     t;
    n = leaves_in_use();
    t.cnt = '0;
    t.sum = '0;
    if (hi >= n) hi = n - 1;
    if (lo <= hi) begin
      a = lo + n;
      b = hi + n;
      while (a <= b) begin
        if ((a & 1) != 0) begin
          if (a < NODE_DEPTH) begin
            t.cnt = t.cnt + hit_tree[a];
            t.sum = t.sum + sum_tree[a];
          end
          a = a + 1;
        end
        if ((b & 1) == 0) begin
          if (b < NODE_DEPTH) begin
            t.cnt = t.cnt + hit_tree[b];
            t.sum = t.sum + sum_tree[b];
          end
          b = b - 1;
        end
        a = a >> 1;
        b = b >> 1;
      end
    end
    return t;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(input int unsigned n);
    case ($urandom_range(9))
      0:       return '0;
      1:       return POS_W'(n - 1);
      2:       return POS_W'($urandom_range(1023));
      3:       return POS_W'(n);
      default: return POS_W'($urandom_range(n - 1));
    endcase
  endfunction

  task automatic push_req(input req_t r, input bit typed, input totals_t typed_t);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.kind;
    req_ch.position_lo <= r.lo;
    req_ch.position_hi <= r.hi;
    req_ch.add_value   <= r.val;
    do @(posedge clk_i); while (!req_ch.ready);
    if (r.kind == REQ_UPDATE) begin
      apply_update(32'(r.lo), r.val);
    end else if (typed) begin
      totals_q = {totals_q, typed_t};
    end else begin
      totals_q = {totals_q, range_total(32'(r.lo), 32'(r.hi))};
    end
  endtask

  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (totals_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_HOLD) @(posedge clk_i);
  endtask

  task automatic write_leaf_count(input logic [LEAF_COUNT_W-1:0] v);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.leaf_count <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    leaf_cfg = v;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // response checker
  always @(posedge clk_i) begin
    totals_t e;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (totals_q.size() == 0) begin
        $error("unexpected response: range_count %0d range_sum %0d",
               rsp_ch.range_count, rsp_ch.range_sum);
        fail_cnt++;
      end else begin
        e = totals_q.pop_front();
        if (rsp_ch.range_count !== e.cnt) begin
          $error("range_count: expected %0d, got %0d", e.cnt, rsp_ch.range_count);
          fail_cnt++;
        end
        if (rsp_ch.range_sum !== e.sum) begin
          $error("range_sum: expected %0d, got %0d", e.sum, rsp_ch.range_sum);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    req_t                    r;
    totals_t                 t;
    logic [LEAF_COUNT_W-1:0] plan [PHASES];
    int unsigned             n;
    logic [POS_W-1:0]        tmp;

    send_idle_pct = 0;
    take_idle_pct = 0;
    for (int i = 0; i < NODE_DEPTH; i++) begin
      sum_tree[i] = '0;
      hit_tree[i] = '0;
    end
    leaf_cfg = LEAF_COUNT_RST;
    plan = '{11'd0, 11'd2047, 11'd1, 11'd2, 11'd1025, 11'd700, 11'd1023, 11'd1024,
             LEAF_COUNT_W'($urandom_range(2047, 1))};

    rst_ni             <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_UPDATE;
    req_ch.position_lo <= '0;
    req_ch.position_hi <= '0;
    req_ch.add_value   <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.leaf_count  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table at the reset leaf count
    for (int i = 0; i < DIR_ROWS; i++) begin
      r.kind = dir_rows[i].kind;
      r.lo   = dir_rows[i].lo;
      r.hi   = dir_rows[i].hi;
      r.val  = dir_rows[i].val;
      t.cnt  = dir_rows[i].cnt;
      t.sum  = dir_rows[i].sum;
      push_req(r, dir_rows[i].typed, t);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_responses();
      if (ph < 3) begin
        send_idle_pct = 30;
        take_idle_pct = 88;
      end else if (ph < 6) begin
        send_idle_pct = 88;
        take_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      write_leaf_count(plan[ph]);
      n = leaves_in_use();
      for (int i = 0; i < PHASE_REQS; i++) begin
        r.kind = ($urandom_range(99) < 55) ? REQ_UPDATE : REQ_QUERY;
        r.lo   = pick_pos(n);
        r.hi   = pick_pos(n);
        if (r.kind == REQ_QUERY && r.lo > r.hi && $urandom_range(3) != 0) begin
          tmp  = r.lo;
          r.lo = r.hi;
          r.hi = tmp;
        end
        case ($urandom_range(7))
          0:       r.val = 32'sh7fffffff;
          1:       r.val = 32'sh80000000;
          2:       r.val = VAL_W'($urandom_range(200)) - 32'sd100;
          default: r.val = $urandom;
        endcase
        push_req(r, 1'b0, t);
      end
    end

    drain_responses();
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
